// File: sv/l2as_pkg.sv
// Package for the log2 artanh-series block: widths, fixed-point constants and pipeline sizes.
package l2as_pkg;

  // Fraction bits of the internal fixed-point arithmetic.
  localparam int FRAC_BITS = 30;

  // IEEE single-precision fraction width, signed exponent width and divisor width.
  localparam int MANT_W = 23;
  localparam int EXP_W  = 9;
  localparam int DEN_W  = MANT_W + 1;

  // Quotient bits resolved per divider stage, and the number of divider stages.
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;

  // Exponent of zero and of denormals (bias plus fraction length).
  localparam logic signed [EXP_W-1:0] ZERO_EXP  = -9'sd150;
  localparam logic signed [EXP_W-1:0] DENORM_EXP = -9'sd149;
  localparam logic [EXP_W-1:0]        EXP_BIAS  = 9'd127;

  // Series coefficients in Q(FRAC_BITS), rounded to nearest.
  localparam logic [FRAC_BITS:0] ONE_Q   = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] THIRD_Q = FRAC_BITS'(((64'd1 << FRAC_BITS) + 64'd1) / 64'd3);
  localparam logic [FRAC_BITS-1:0] FIFTH_Q = FRAC_BITS'(((64'd1 << FRAC_BITS) + 64'd2) / 64'd5);

  // log2(e) in Q60, split into 32-bit halves for two narrower products.
  localparam logic [63:0] LOG2E_Q60 = 64'h171547652B82FE17;
  localparam logic [31:0] LOG2E_LO  = LOG2E_Q60[31:0];
  localparam logic [31:0] LOG2E_HI  = LOG2E_Q60[63:32];
  localparam int          LOG2E_SHIFT = 59;

  // Widths of the series sum, its log2(e) products and rounding sum; output fraction bits.
  localparam int S_W    = FRAC_BITS + 1;
  localparam int PART_W = S_W + 32;
  localparam int SUM_W  = PART_W + 33;
  localparam int RND_W  = S_W + 1;
  localparam int OUT_FRAC = 23;

endpackage

// File: sv/l2as_if.sv
// Stream interfaces for the operand and result channels.
interface l2as_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  modport source (output valid, output value_bits, input ready);
  modport sink   (input valid, input value_bits, output ready);
endinterface

interface l2as_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] log2_fixed;
  modport source (output valid, output log2_fixed, input ready);
  modport sink   (input valid, input log2_fixed, output ready);
endinterface

// File: sv/log2_artanh_series_top.sv
// Pipelined fixed-point log2 of a single-precision bit pattern, output in signed Q9.23.
// The block accepts one operand per cycle unless a result is held back and returns one
// result per operand, in order, through one input stage, one decode stage with the
// denormal leading-one search, a restoring divider for the series argument
// q = f / (2^23 + f), f being the 23-bit fraction, resolving two quotient bits per
// stage, four stages that evaluate the series with one multiplication each, one
// stage that scales by log2(e) with two partial products, and the output register. The
// whole pipeline holds while a result waits to be taken, so a stall loses and repeats
// nothing. The sign bit is ignored; zero gives -150.0 and infinity or NaN are handled
// as exponent 128.
module log2_artanh_series_top
  import l2as_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  l2as_in_if.sink    operand,
  l2as_out_if.source result
);

  // Global advance: the pipeline moves unless a finished result is held back.
  logic en;
  logic out_v;
  logic signed [31:0] out_res;

  assign en            = !out_v || result.ready;
  assign operand.ready = en;

  // Input stage: capture the transfer.
  logic        v0;
  logic [30:0] b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= operand.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0 <= operand.value_bits[30:0];
    end
  end

  // Decode: split exponent and fraction, normalise denormals.
  logic [7:0]              expf;
  logic [MANT_W-1:0]       frac;
  logic [4:0]              lead;
  logic signed [EXP_W-1:0] dec_e;
  logic [MANT_W-1:0]       dec_f;

  assign expf = b0[30:23];
  assign frac = b0[MANT_W-1:0];

  always_comb begin
    lead = '0;
    for (int i = 0; i < MANT_W; i++) begin
      if (frac[i]) begin
        lead = 5'(i);
      end
    end
  end

  always_comb begin
    if (expf == 8'd0) begin
      if (frac == '0) begin
        dec_e = ZERO_EXP;
        dec_f = '0;
      end else begin
        dec_e = DENORM_EXP + $signed({4'd0, lead});
        dec_f = frac << (5'(MANT_W) - lead);
      end
    end else begin
      dec_e = $signed({1'b0, expf} - EXP_BIAS);
      dec_f = frac;
    end
  end

  // Divider pipeline; entry 0 is the decode register.
  logic                    dv   [DIV_STAGES+1];
  logic signed [EXP_W-1:0] de   [DIV_STAGES+1];
  logic [DEN_W-1:0]        dden [DIV_STAGES+1];
  logic [DEN_W-1:0]        drem [DIV_STAGES+1];
  logic [FRAC_BITS-1:0]    dquo [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      de[0]   <= dec_e;
      dden[0] <= {1'b1, dec_f};
      drem[0] <= {1'b0, dec_f};
      dquo[0] <= '0;
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [DEN_W-1:0]     rem_n;
    logic [FRAC_BITS-1:0] quo_n;
    logic [DEN_W:0]       sh;

    // Restoring division steps; the numerator's low bits are all zero.
    always_comb begin
      rem_n = drem[k-1];
      quo_n = dquo[k-1];
      sh    = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        if ((k - 1) * DIV_STEPS + j < FRAC_BITS) begin
          sh = {rem_n, 1'b0};
          if (sh >= {1'b0, dden[k-1]}) begin
            rem_n = DEN_W'(sh - {1'b0, dden[k-1]});
            quo_n = {quo_n[FRAC_BITS-2:0], 1'b1};
          end else begin
            rem_n = sh[DEN_W-1:0];
            quo_n = {quo_n[FRAC_BITS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (en) begin
        dv[k] <= dv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        de[k]   <= de[k-1];
        dden[k] <= dden[k-1];
        drem[k] <= rem_n;
        dquo[k] <= quo_n;
      end
    end
  end

  // Series stages: valid bits.
  logic v1, v2, v3, v4, v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      v5    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1    <= dv[DIV_STAGES];
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      v5    <= v4;
      out_v <= v5;
    end
  end

  // Series stage 1: q squared.
  logic [FRAC_BITS-1:0]    q1, q2_1;
  logic signed [EXP_W-1:0] e1;
  logic [2*FRAC_BITS-1:0]  p_qq;

  assign p_qq = (2*FRAC_BITS)'(dquo[DIV_STAGES]) * (2*FRAC_BITS)'(dquo[DIV_STAGES]);

  always_ff @(posedge clk) begin
    if (en) begin
      q1   <= dquo[DIV_STAGES];
      q2_1 <= p_qq[2*FRAC_BITS-1:FRAC_BITS];
      e1   <= de[DIV_STAGES];
    end
  end

  // Series stage 2: q^2 / 5.
  logic [FRAC_BITS-1:0]    q_2, qq_2, a_2;
  logic signed [EXP_W-1:0] e2;
  logic [2*FRAC_BITS-1:0]  p_a;

  assign p_a = (2*FRAC_BITS)'(q2_1) * (2*FRAC_BITS)'(FIFTH_Q);

  always_ff @(posedge clk) begin
    if (en) begin
      q_2  <= q1;
      qq_2 <= q2_1;
      a_2  <= p_a[2*FRAC_BITS-1:FRAC_BITS];
      e2   <= e1;
    end
  end

  // Series stage 3: (1/3 + q^2/5) * q^2 + 1.
  logic [FRAC_BITS-1:0]    q_3;
  logic [S_W-1:0]          s1_3;
  logic signed [EXP_W-1:0] e3;
  logic [S_W-1:0]          c_3;
  logic [S_W+FRAC_BITS-1:0] p_c;

  assign c_3 = S_W'(THIRD_Q) + S_W'(a_2);
  assign p_c = (S_W+FRAC_BITS)'(c_3) * (S_W+FRAC_BITS)'(qq_2);

  always_ff @(posedge clk) begin
    if (en) begin
      q_3  <= q_2;
      s1_3 <= p_c[S_W+FRAC_BITS-1:FRAC_BITS] + ONE_Q;
      e3   <= e2;
    end
  end

  // Series stage 4: multiply by q.
  logic [S_W-1:0]           s_4;
  logic signed [EXP_W-1:0]  e4;
  logic [S_W+FRAC_BITS-1:0] p_s;

  assign p_s = (S_W+FRAC_BITS)'(s1_3) * (S_W+FRAC_BITS)'(q_3);

  always_ff @(posedge clk) begin
    if (en) begin
      s_4 <= p_s[S_W+FRAC_BITS-1:FRAC_BITS];
      e4  <= e3;
    end
  end

  // Scale stage: two partial products with log2(e).
  logic [PART_W-1:0]       plo_5, phi_5;
  logic signed [EXP_W-1:0] e5;

  always_ff @(posedge clk) begin
    if (en) begin
      plo_5 <= PART_W'(s_4) * PART_W'(LOG2E_LO);
      phi_5 <= PART_W'(s_4) * PART_W'(LOG2E_HI);
      e5    <= e4;
    end
  end

  // Output stage: combine, round to 23 fraction bits and add the exponent.
  logic [SUM_W-1:0] sum_6;
  logic [S_W-1:0]   t_6;
  logic [RND_W-1:0] rnd_6;
  logic [31:0]      res_6;

  assign sum_6 = (SUM_W'(phi_5) << 32) + SUM_W'(plo_5);
  assign t_6   = sum_6[LOG2E_SHIFT +: S_W];
  assign rnd_6 = RND_W'(t_6) + (RND_W'(1) << (FRAC_BITS - OUT_FRAC - 1));
  assign res_6 = {e5, {OUT_FRAC{1'b0}}} + 32'(rnd_6 >> (FRAC_BITS - OUT_FRAC));

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= $signed(res_6);
    end
  end

  assign result.valid      = out_v;
  assign result.log2_fixed = out_res;

  // The input is refused only while a finished result is held back.
  assert property (@(posedge clk) disable iff (rst)
    !operand.ready |-> (out_v && !result.ready))
    else $error("input stalled without output backpressure");

  // A held result keeps the pipeline frozen behind it.
  assert property (@(posedge clk) disable iff (rst)
    (out_v && !result.ready) |=> (out_v && $stable(v5) && $stable(dv[DIV_STAGES])))
    else $error("pipeline moved during a stall");

  // Decoded exponent stays within the zero to infinity range.
  assert property (@(posedge clk) disable iff (rst)
    dv[0] |-> (de[0] >= ZERO_EXP && de[0] <= 9'sd128))
    else $error("decoded exponent out of range");

  // The quotient f / (2^23 + f) stays below one half.
  assert property (@(posedge clk) disable iff (rst)
    v1 |-> (q1[FRAC_BITS-1] == 1'b0))
    else $error("series argument out of range");

endmodule

// File: tb/sv/log2_artanh_series_checker.sv
// Checker for the log2 block: predicts each result from the operand transfers and compares.
module log2_artanh_series_checker
  import l2as_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  l2as_in_if.sink  operand,
  l2as_out_if.sink result,
  input  logic     watch_ready,
  output int       fail_count,
  output int       pending
);

  logic signed [31:0] log2_expected [$];

  // Exact product of two values, shifted right; wide enough for every operand here.
  function automatic logic [63:0] mul_down(input logic [63:0] a, input logic [63:0] b,
                                           input int sh);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod >> sh);
  endfunction

  // Fixed-point log2 of one bit pattern, in Q9.23.
  function automatic logic signed [31:0] predict_log2(input logic [31:0] bits);
    logic [7:0]  expf;
    logic [22:0] frac;
    int          e;
    int          p;
    logic [63:0] unity, third, fifth, q, q2, s, t, frac23;
    logic [31:0] res;
    expf  = bits[30:23];
    frac  = bits[22:0];
    unity = 64'd1 << FRAC_BITS;
    third = (unity + 64'd1) / 64'd3;
    fifth = (unity + 64'd2) / 64'd5;
    if (expf == 8'd0) begin
      if (frac == 23'd0) begin
        e = -150;
      end else begin
        p = 22;
        while (p > 0 && !frac[p]) p--;
        e = p - 149;
        frac = 23'({9'd0, frac} << (23 - p));
      end
    end else begin
      e = int'(expf) - 127;
    end
    q  = ({41'd0, frac} << FRAC_BITS) / ((64'd1 << 23) + {41'd0, frac});
    q2 = mul_down(q, q, FRAC_BITS);
    s  = third + mul_down(q2, fifth, FRAC_BITS);
    s  = mul_down(s, q2, FRAC_BITS) + unity;
    s  = mul_down(s, q, FRAC_BITS);
    t  = mul_down(s, LOG2E_Q60, 59);
    frac23 = (t + (64'd1 << (FRAC_BITS - 24))) >> (FRAC_BITS - 23);
    res = (32'(e) << 23) + frac23[31:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  assign pending = log2_expected.size();

  // Queue predictions on operand transfers and check each result transfer.
  always @(posedge clk) begin
    if (rst) begin
      log2_expected.delete();
    end else begin
      if (result.valid && watch_ready) begin
        if (log2_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", result.log2_fixed));
        end else begin
          if (result.log2_fixed !== log2_expected[0])
            report_mismatch($sformatf("log2_fixed %h, predicted %h",
                                      result.log2_fixed, log2_expected[0]));
          void'(log2_expected.pop_front());
        end
      end
      if (operand.valid && operand.ready)
        log2_expected.push_back(predict_log2(operand.value_bits));
    end
  end

  initial fail_count = 0;

endmodule

// File: tb/sv/log2_artanh_series_top_test.sv
// Testbench top for the log2 block: clock, reset, operand stimulus and the verdict.
module log2_artanh_series_top_test;
  import l2as_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   calm;

  l2as_in_if  operand ();
  l2as_out_if result ();

  log2_artanh_series_top uut (.clk(clk), .rst(rst), .operand(operand), .result(result));

  log2_artanh_series_checker checker_i (
    .clk(clk), .rst(rst), .operand(operand), .result(result),
    .watch_ready(result.ready), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, none while calm.
  initial result.ready = 1'b0;
  always @(posedge clk) begin
    result.ready <= calm || ($urandom_range(99) >= 28);
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (operand.valid && operand.ready) || (result.valid && result.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one operand and hold it until its transfer.
  task automatic send_operand(input logic [31:0] bits);
    while (!calm && $urandom_range(99) < 28) begin
      operand.valid <= 1'b0;
      @(posedge clk);
    end
    operand.valid      <= 1'b1;
    operand.value_bits <= bits;
    @(posedge clk);
    while (!operand.ready) @(posedge clk);
  endtask

  // Random pattern biased towards every exponent class.
  function automatic logic [31:0] random_pattern();
    logic [31:0] bits;
    bits = $urandom;
    case ($urandom_range(9))
      0: bits[30:23] = 8'd0;
      1: bits[30:23] = 8'hFF;
      2: bits[22:0] = 23'(1) << $urandom_range(22);
      3: bits[22:0] = 23'd0;
      default: ;
    endcase
    return bits;
  endfunction

  initial begin
    logic [31:0] directed [$];
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0040_0000,
                 32'h007F_FFFF, 32'h0000_0100, 32'h0080_0000, 32'h3F80_0000,
                 32'hBF80_0000, 32'h3FFF_FFFF, 32'h3FC0_0000, 32'h4000_0000,
                 32'h7F7F_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
                 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h3F80_0001, 32'h0000_0003};
    calm = 1'b0;
    idle_cycles = 0;
    operand.valid = 1'b0;
    operand.value_bits = '0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_operand(directed[i]);
    // Hold off until the pipeline has drained once.
    operand.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < 1850; n++) begin
      calm = (n >= 600 && n < 900);
      send_operand(random_pattern());
    end
    calm = 1'b0;
    operand.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/l2as_pkg.sv
sv/l2as_if.sv
sv/log2_artanh_series_top.sv
tb/sv/log2_artanh_series_checker.sv
tb/sv/log2_artanh_series_top_test.sv
